### sv/baldq_pkg.sv
// Shared types and constants for the bounded array-list deque.
// Holds operation/status codes, controller states and the command/status structs.
// No dependencies.
package baldq_pkg;

   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_ELEM_WIDTH = 32;

   localparam int OP_W        = 3;
   localparam int ELEM_IN_W   = 32;
   localparam int POS_W       = 16;
   localparam int ELEM_OUT_W  = 32;
   localparam int COUNT_OUT_W = 9;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD   = 3'd0,
      OP_INS_TAIL   = 3'd1,
      OP_REM_HEAD   = 3'd2,
      OP_REM_TAIL   = 3'd3,
      OP_READ_HEAD  = 3'd4,
      OP_READ_TAIL  = 3'd5,
      OP_READ_INDEX = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_PUT_HEAD,
      S_DONE
   } state_type;

   // sweep counter commands
   typedef enum logic [2:0] {
      SW_HOLD,
      SW_OPEN_INS,
      SW_NEXT_INS,
      SW_OPEN_REM,
      SW_NEXT_REM
   } sweep_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_HEAD,
      RD_TAIL,
      RD_INDEX,
      RD_SWEEP
   } rd_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_HEAD,
      WR_TAIL,
      WR_SWEEP
   } wr_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_type;

   typedef struct packed {
      logic      latch;
      sweep_type sweep;
      rd_type    rd;
      wr_type    wr;
      cnt_type   cnt;
      logic      set_result;
      logic      rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            single;
      logic            idx_zero;
      logic            idx_last;
      logic            rsp_free;
   } sts_type;

endpackage

### sv/baldq_req_if.sv
// Request channel of the bounded array-list deque: valid/ready plus one operation.
// Uses field widths from baldq_pkg.
interface baldq_req_if;
   logic                             valid;
   logic                             ready;
   logic [baldq_pkg::OP_W-1:0]       operation;
   logic [baldq_pkg::ELEM_IN_W-1:0]  element_in;
   logic signed [baldq_pkg::POS_W-1:0] position;

   modport source (output valid, output operation, output element_in, output position,
                   input ready);
   modport sink (input valid, input operation, input element_in, input position,
                 output ready);
endinterface

### sv/baldq_rsp_if.sv
// Response channel of the bounded array-list deque: valid/ready plus one result.
// Uses field widths from baldq_pkg.
interface baldq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [baldq_pkg::ELEM_OUT_W-1:0]   element_out;
   logic [baldq_pkg::COUNT_OUT_W-1:0]  count;
   logic [baldq_pkg::STATUS_W-1:0]     status;

   modport source (output valid, output element_out, output count, output status,
                   input ready);
   modport sink (input valid, input element_out, input count, input status,
                 output ready);
endinterface

### sv/bounded_array_list_deque.sv
// Top level of the bounded array-list deque: joins controller and datapath to
// the request and response channels. Depends on baldq_pkg, baldq_req_if,
// baldq_rsp_if, baldq_ctrl and baldq_dpath.

// Ordered list of up to CAPACITY elements kept in a single-port-write,
// single-port-read memory, one operation per request transaction and one
// result transaction per request. Items are handled one at a time: the block
// takes a request in its idle cycle, decodes it the next cycle, runs any entry
// move and posts the result once the output register is free. Insert at head
// with n entries present moves every entry up one place through the memory at
// one entry per cycle and then writes the new head; remove head with n >= 2
// entries moves n - 1 entries down. That entry-move sweep over the memory
// ports sets the rate. The result sits in an output register, so the next
// request is taken while a finished result still waits; a new result waits
// only if the old one is still held. Reset clears the list at once: a fill
// mark records the written prefix of the memory, and reads past it return
// zero, so there is no clearing pass. A read by index clamps to
// 0..CAPACITY-1 and may return entries past the count.
module bounded_array_list_deque #(
   parameter int CAPACITY   = baldq_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = baldq_pkg::DEF_ELEM_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   baldq_req_if.sink  req_chan,
   baldq_rsp_if.source rsp_chan
);

   baldq_pkg::cmd_type cmd;
   baldq_pkg::sts_type sts;
   logic               req_ready;

   // controller: owns the request handshake and sequences every transaction
   baldq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: entry memory, count, fill mark and the response register
   baldq_dpath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_chan.operation),
      .req_element_in  (req_chan.element_in),
      .req_position    (req_chan.position),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_element_out (rsp_chan.element_out),
      .rsp_count       (rsp_chan.count),
      .rsp_status      (rsp_chan.status)
   );

   // drive ready from the controller's idle cycle only
   assign req_chan.ready = req_ready;

endmodule

### sv/baldq_dpath.sv
// Datapath of the bounded array-list deque: entry memory, count, fill mark,
// sweep address counters and the response register. Depends on baldq_pkg.
module baldq_dpath #(
   parameter int CAPACITY   = baldq_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = baldq_pkg::DEF_ELEM_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  baldq_pkg::cmd_type                    cmd,
   output baldq_pkg::sts_type                    sts,
   input  logic [baldq_pkg::OP_W-1:0]            req_operation,
   input  logic [baldq_pkg::ELEM_IN_W-1:0]       req_element_in,
   input  logic signed [baldq_pkg::POS_W-1:0]    req_position,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [baldq_pkg::ELEM_OUT_W-1:0]      rsp_element_out,
   output logic [baldq_pkg::COUNT_OUT_W-1:0]     rsp_count,
   output logic [baldq_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [baldq_pkg::OP_W-1:0] op_ff;
   logic [ELEM_WIDTH-1:0]      elem_ff;
   logic [ADDR_W-1:0]          pos_ff, pos_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [ADDR_W-1:0] count_m1, count_a;

   logic [ELEM_WIDTH-1:0] mem [CAPACITY];
   logic [ELEM_WIDTH-1:0] rdata_ff;
   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;

   baldq_pkg::status_type status_ff, status_in;
   logic                  hit_ff, hit_in;

   logic                                 rsp_valid_ff;
   logic [baldq_pkg::ELEM_OUT_W-1:0]     rsp_element_ff;
   logic [baldq_pkg::COUNT_OUT_W-1:0]    rsp_count_ff;
   logic [baldq_pkg::STATUS_W-1:0]       rsp_status_ff;

   // clamp position: negative to head, past the store to the last entry
   always_comb begin
      if (req_position[baldq_pkg::POS_W-1]) begin
         pos_in = '0;
      end else if ({1'b0, req_position[baldq_pkg::POS_W-2:0]} >=
                   baldq_pkg::POS_W'(CAPACITY)) begin
         pos_in = ADDR_W'(CAPACITY - 1);
      end else begin
         pos_in = req_position[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         elem_ff <= ELEM_WIDTH'(req_element_in);
         pos_ff  <= pos_in;
      end
   end

   assign count_m1 = ADDR_W'(count_ff - CNT_W'(1));
   assign count_a  = ADDR_W'(count_ff);

   always_comb begin
      case (cmd.cnt)
         baldq_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
         baldq_pkg::CNT_DEC: count_in = count_ff - CNT_W'(1);
         default:            count_in = count_ff;
      endcase
   end

   // every write lands below the count it produces, so the largest count seen
   // marks the end of the written prefix
   assign hw_in = (count_in > hw_ff) ? count_in : hw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hw_ff    <= '0;
      end else begin
         count_ff <= count_in;
         hw_ff    <= hw_in;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      dst_in = dst_ff;
      case (cmd.sweep)
         baldq_pkg::SW_OPEN_INS: begin
            idx_in = count_m1;
            dst_in = count_a;
         end
         baldq_pkg::SW_NEXT_INS: begin
            idx_in = idx_ff - ADDR_W'(1);
            dst_in = idx_ff;
         end
         baldq_pkg::SW_OPEN_REM: begin
            idx_in = ADDR_W'(1);
            dst_in = '0;
         end
         baldq_pkg::SW_NEXT_REM: begin
            idx_in = idx_ff + ADDR_W'(1);
            dst_in = idx_ff;
         end
         default: begin
            idx_in = idx_ff;
            dst_in = dst_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dst_ff <= dst_in;
   end

   always_comb begin
      case (cmd.rd)
         baldq_pkg::RD_HEAD:  rd_addr = '0;
         baldq_pkg::RD_TAIL:  rd_addr = count_m1;
         baldq_pkg::RD_INDEX: rd_addr = pos_ff;
         baldq_pkg::RD_SWEEP: rd_addr = idx_in;
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr)
         baldq_pkg::WR_HEAD: begin
            wr_addr = '0;
            wr_data = elem_ff;
         end
         baldq_pkg::WR_TAIL: begin
            wr_addr = count_a;
            wr_data = elem_ff;
         end
         baldq_pkg::WR_SWEEP: begin
            wr_addr = dst_ff;
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = elem_ff;
         end
      endcase
   end

   assign rd_en = (cmd.rd != baldq_pkg::RD_NONE);
   assign wr_en = (cmd.wr != baldq_pkg::WR_NONE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // status from the count before the operation
   always_comb begin
      status_in = baldq_pkg::ST_OK;
      hit_in    = 1'b0;
      case (op_ff)
         baldq_pkg::OP_INS_HEAD, baldq_pkg::OP_INS_TAIL: begin
            if (sts.full) status_in = baldq_pkg::ST_FULL;
         end
         baldq_pkg::OP_REM_HEAD: begin
            if (sts.empty) status_in = baldq_pkg::ST_EMPTY;
         end
         baldq_pkg::OP_READ_HEAD, baldq_pkg::OP_READ_TAIL: begin
            if (sts.empty) status_in = baldq_pkg::ST_EMPTY;
            else           hit_in    = 1'b1;
         end
         baldq_pkg::OP_READ_INDEX: begin
            // never-written entries read as zero
            hit_in = (CNT_W'(pos_ff) < hw_ff);
         end
         default: begin
            status_in = baldq_pkg::ST_OK;
            hit_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_element_ff <= hit_ff ? baldq_pkg::ELEM_OUT_W'(rdata_ff) : '0;
         rsp_count_ff   <= baldq_pkg::COUNT_OUT_W'(count_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   assign sts.op       = op_ff;
   assign sts.full     = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty    = (count_ff == '0);
   assign sts.single   = (count_ff == CNT_W'(1));
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.idx_last = (idx_ff == count_m1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_fill_mark: assert property (@(posedge clock) disable iff (reset)
      hw_ff >= count_ff)
      else $error("fill mark below entry count");

   a_sweep_ports: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr == baldq_pkg::WR_SWEEP && cmd.rd == baldq_pkg::RD_SWEEP) |->
      (wr_addr != rd_addr))
      else $error("sweep reads and writes the same entry");

endmodule

### sv/baldq_ctrl.sv
// Controller of the bounded array-list deque: decodes each operation and
// sequences memory sweeps. Depends on baldq_pkg; drives baldq_dpath commands.
module baldq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  baldq_pkg::sts_type sts,
   output baldq_pkg::cmd_type cmd
);

   baldq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= baldq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.latch      = 1'b0;
      cmd.sweep      = baldq_pkg::SW_HOLD;
      cmd.rd         = baldq_pkg::RD_NONE;
      cmd.wr         = baldq_pkg::WR_NONE;
      cmd.cnt        = baldq_pkg::CNT_HOLD;
      cmd.set_result = 1'b0;
      cmd.rsp_load   = 1'b0;
      case (state_ff)
         baldq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = baldq_pkg::S_EXEC;
            end
         end
         baldq_pkg::S_EXEC: begin
            cmd.set_result = 1'b1;
            state_in       = baldq_pkg::S_DONE;
            case (sts.op)
               baldq_pkg::OP_INS_HEAD: begin
                  if (!sts.full) begin
                     if (sts.empty) begin
                        state_in = baldq_pkg::S_PUT_HEAD;
                     end else begin
                        cmd.sweep = baldq_pkg::SW_OPEN_INS;
                        cmd.rd    = baldq_pkg::RD_SWEEP;
                        state_in  = baldq_pkg::S_SHIFT_UP;
                     end
                  end
               end
               baldq_pkg::OP_INS_TAIL: begin
                  if (!sts.full) begin
                     cmd.wr  = baldq_pkg::WR_TAIL;
                     cmd.cnt = baldq_pkg::CNT_INC;
                  end
               end
               baldq_pkg::OP_REM_HEAD: begin
                  if (!sts.empty) begin
                     if (sts.single) begin
                        cmd.cnt = baldq_pkg::CNT_DEC;
                     end else begin
                        cmd.sweep = baldq_pkg::SW_OPEN_REM;
                        cmd.rd    = baldq_pkg::RD_SWEEP;
                        state_in  = baldq_pkg::S_SHIFT_DN;
                     end
                  end
               end
               baldq_pkg::OP_REM_TAIL: begin
                  if (!sts.empty) cmd.cnt = baldq_pkg::CNT_DEC;
               end
               baldq_pkg::OP_READ_HEAD: begin
                  if (!sts.empty) cmd.rd = baldq_pkg::RD_HEAD;
               end
               baldq_pkg::OP_READ_TAIL: begin
                  if (!sts.empty) cmd.rd = baldq_pkg::RD_TAIL;
               end
               baldq_pkg::OP_READ_INDEX: begin
                  cmd.rd = baldq_pkg::RD_INDEX;
               end
               default: begin
                  state_in = baldq_pkg::S_DONE;
               end
            endcase
         end
         baldq_pkg::S_SHIFT_UP: begin
            cmd.wr = baldq_pkg::WR_SWEEP;
            if (sts.idx_zero) begin
               state_in = baldq_pkg::S_PUT_HEAD;
            end else begin
               cmd.sweep = baldq_pkg::SW_NEXT_INS;
               cmd.rd    = baldq_pkg::RD_SWEEP;
            end
         end
         baldq_pkg::S_SHIFT_DN: begin
            cmd.wr = baldq_pkg::WR_SWEEP;
            if (sts.idx_last) begin
               cmd.cnt  = baldq_pkg::CNT_DEC;
               state_in = baldq_pkg::S_DONE;
            end else begin
               cmd.sweep = baldq_pkg::SW_NEXT_REM;
               cmd.rd    = baldq_pkg::RD_SWEEP;
            end
         end
         baldq_pkg::S_PUT_HEAD: begin
            cmd.wr   = baldq_pkg::WR_HEAD;
            cmd.cnt  = baldq_pkg::CNT_INC;
            state_in = baldq_pkg::S_DONE;
         end
         baldq_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = baldq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = baldq_pkg::S_IDLE;
         end
      endcase
   end

   a_latch_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (state_ff == baldq_pkg::S_EXEC))
      else $error("accepted transaction not decoded next cycle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response register overwritten while occupied");

   a_sweep_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == baldq_pkg::S_SHIFT_UP || state_ff == baldq_pkg::S_SHIFT_DN) |->
      (cmd.wr == baldq_pkg::WR_SWEEP && !cmd.latch))
      else $error("sweep cycle without entry move");

endmodule
